[rtl/stpm_pkg.sv]
// Shared constants, register indexes, mode codes and types for the trip point monitor.
`timescale 1ns / 1ps

package stpm_pkg;

    localparam int DATA_W              = 64;
    localparam int HW_POINTS           = 4;
    localparam int PT_IDX_W            = 2;
    localparam int CFG_IDX_W           = 3;
    localparam int MODE_W              = 2;
    localparam int POINTS_W            = 3;
    localparam int NUM_TRIP_POINTS_DEF = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR0   = 3'd3;

    // per-point crossing modes
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RISE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FALL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BOTH = 2'd3;

    // sequencer status toward the datapath
    typedef struct packed {
        logic busy;   // an item is in work, input is held off
        logic step;   // the current point is checked this cycle; write its flag
    } t_seq_ctl;

endpackage

[rtl/stpm_cmp.sv]
// Shared compare unit: one threshold compare and the crossing decision for one point.
`timescale 1ns / 1ps

module stpm_cmp
    import stpm_pkg::*;
(
    input  logic [DATA_W-1:0] i_sample,
    input  logic [DATA_W-1:0] i_threshold,
    input  logic              i_old_above,
    input  logic [MODE_W-1:0] i_mode,
    output logic              o_now_above,
    output logic              o_fire
);

    always_comb begin
        o_now_above = (i_sample > i_threshold);
        case (i_mode)
            MODE_OFF:  o_fire = 1'b0;
            MODE_RISE: o_fire = !i_old_above && o_now_above;
            MODE_FALL: o_fire = i_old_above && !o_now_above;
            MODE_BOTH: o_fire = i_old_above != o_now_above;
            default:   o_fire = 1'b0;
        endcase
    end

endmodule

[rtl/stpm_seq.sv]
// Point sequencer: walks the points in use, holds one pending event and drives the output word.
`timescale 1ns / 1ps

module stpm_seq
    import stpm_pkg::*;
#(
    parameter int CNT_W = 3,
    parameter int IDX_W = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CNT_W-1:0]    i_count,
    input  logic                i_now_above,
    input  logic                i_fire,
    input  logic                i_out_stall,
    output t_seq_ctl            o_ctl,
    output logic [IDX_W-1:0]    o_ptr,
    output logic                o_out_valid,
    output logic [PT_IDX_W-1:0] o_out_index,
    output logic                o_out_above,
    output logic                o_out_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_ptr, n_ptr;
    logic                r_pend_valid, n_pend_valid;
    logic [PT_IDX_W-1:0] r_pend_index, n_pend_index;
    logic                r_pend_above, n_pend_above;
    logic                r_out_valid, n_out_valid;
    logic [PT_IDX_W-1:0] r_out_index, n_out_index;
    logic                r_out_above, n_out_above;
    logic                r_out_last, n_out_last;
    logic                out_free;
    logic                step;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_pend_valid = r_pend_valid;
        n_pend_index = r_pend_index;
        n_pend_above = r_pend_above;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_index  = r_out_index;
        n_out_above  = r_out_above;
        n_out_last   = r_out_last;
        step         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                    n_ptr   = '0;
                end
            end
            ST_RUN: begin
                if (r_ptr == i_count) begin
                    n_state = r_pend_valid ? ST_FLUSH : ST_IDLE;
                end else if (!(i_fire && r_pend_valid && !out_free)) begin
                    step  = 1'b1;
                    n_ptr = r_ptr + 1'b1;
                    if (i_fire) begin
                        // a newer event exists, so the pending one is not the last
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_index = r_pend_index;
                            n_out_above = r_pend_above;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_index = PT_IDX_W'(r_ptr[IDX_W-1:0]);
                        n_pend_above = i_now_above;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_index  = r_pend_index;
                    n_out_above  = r_pend_above;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ptr        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ptr        <= n_ptr;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_index <= n_pend_index;
        r_pend_above <= n_pend_above;
        r_out_index  <= n_out_index;
        r_out_above  <= n_out_above;
        r_out_last   <= n_out_last;
    end

    assign o_ctl.busy  = (r_state != ST_IDLE);
    assign o_ctl.step  = step;
    assign o_ptr       = r_ptr[IDX_W-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_above = r_out_above;
    assign o_out_last  = r_out_last;

endmodule

[rtl/sensor_trip_point_monitor_core.sv]
// Top level of the sensor trip point monitor: configuration, flags and sample hold.
`timescale 1ns / 1ps

// Sensor trip point monitor. Each accepted 64-bit reading is compared, one trip point per
// cycle on a single shared 64-bit comparator, against the thresholds of the points in use
// (the smaller of points_in_use and NUM_TRIP_POINTS, at most four), starting at point 0;
// the walk pauses while a new event waits behind a stalled output word. Each point whose
// crossing fires under its mode (off, rising, falling, either) produces one output word
// carrying the point index, its new above flag and a last marker on the final word of that
// reading; every checked point's flag then takes reading > threshold. o_sample_stall stays
// high while a reading's points are walked, while its final event is flushed when any
// fired, and while the output side stalls, so a new reading is taken only once the last
// one is done. The newest firing event is held back until the next one fires or the walk
// ends, so the last marker can be set. With monitoring disabled a reading is accepted and
// dropped without stalling the input. Configuration writes are always ready; a threshold
// write clears that point's above flag. There is no clearing pass after reset.

module sensor_trip_point_monitor_core
    import stpm_pkg::*;
#(
    parameter int NUM_TRIP_POINTS = NUM_TRIP_POINTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // reading input
    input  logic                 i_sample_valid,
    output logic                 o_sample_stall,
    input  logic [DATA_W-1:0]    i_sample_value,
    // trip event output
    output logic                 o_trip_valid,
    input  logic                 i_trip_stall,
    output logic [PT_IDX_W-1:0]  o_trip_index,
    output logic                 o_now_above,
    output logic                 o_last_event,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    // points that can ever be checked: limited by the registers that exist
    localparam int PTS   = (NUM_TRIP_POINTS < HW_POINTS) ? NUM_TRIP_POINTS : HW_POINTS;
    localparam int CNT_W = $clog2(PTS + 1);
    localparam int IDX_W = (PTS > 1) ? $clog2(PTS) : 1;

    logic                r_enable;
    logic [POINTS_W-1:0] r_points;
    logic [7:0]          r_modes;
    logic [DATA_W-1:0]   r_thr [PTS];
    logic [PTS-1:0]      r_above;
    logic [DATA_W-1:0]   r_sample;

    t_seq_ctl            seq_ctl;
    logic [IDX_W-1:0]    ptr;
    logic [CNT_W-1:0]    active_count;
    logic [MODE_W-1:0]   cur_mode;
    logic                now_above;
    logic                fire;
    logic                in_accept;
    logic                cfg_write;

    assign in_accept   = i_sample_valid && !o_sample_stall;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    // clamp the point count to what this build supports
    assign active_count = (r_points > POINTS_W'(PTS)) ? CNT_W'(PTS) : CNT_W'(r_points);

    assign cur_mode = r_modes[MODE_W*ptr +: MODE_W];

    // configuration registers; hold them across readings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_points <= '0;
            r_modes  <= '0;
        end else if (cfg_write) begin
            case (i_cfg_index)
                REG_ENABLE: r_enable <= i_cfg_data[0];
                REG_POINTS: r_points <= i_cfg_data[POINTS_W-1:0];
                REG_MODES:  r_modes  <= i_cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // thresholds and above flags; a threshold write drops the flag of its point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above <= '0;
            for (int k = 0; k < PTS; k++) begin
                r_thr[k] <= '0;
            end
        end else begin
            if (seq_ctl.step) begin
                r_above[ptr] <= now_above;
            end
            if (cfg_write) begin
                for (int k = 0; k < PTS; k++) begin
                    if (i_cfg_index == CFG_IDX_W'(int'(REG_THR0) + k)) begin
                        r_thr[k]   <= i_cfg_data;
                        r_above[k] <= 1'b0;
                    end
                end
            end
        end
    end

    // hold the reading while its points are walked
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_sample_value;
        end
    end

    stpm_cmp u_cmp (
        .i_sample    (r_sample),
        .i_threshold (r_thr[ptr]),
        .i_old_above (r_above[ptr]),
        .i_mode      (cur_mode),
        .o_now_above (now_above),
        .o_fire      (fire)
    );

    stpm_seq #(
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_accept && r_enable),
        .i_count     (active_count),
        .i_now_above (now_above),
        .i_fire      (fire),
        .i_out_stall (i_trip_stall),
        .o_ctl       (seq_ctl),
        .o_ptr       (ptr),
        .o_out_valid (o_trip_valid),
        .o_out_index (o_trip_index),
        .o_out_above (o_now_above),
        .o_out_last  (o_last_event)
    );

    assign o_sample_stall = seq_ctl.busy;

    // an enabled reading always makes the block busy in the cycle after it is accepted
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_enable) |=> o_sample_stall)
        else $error("enabled reading did not start the walk");

    // a word that is not the last leaves another event still in work
    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_trip_valid && !o_last_event) |-> o_sample_stall)
        else $error("non-last trip word with the block idle");

    // flags change from readings only while a walk is running
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_ctl.step |-> seq_ctl.busy)
        else $error("flag update outside a walk");

    // reported points are always ones this build can check
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_trip_valid |-> (int'(o_trip_index) < PTS))
        else $error("trip index beyond supported points");

endmodule
